// ----- sv/assert_macros.svh -----
// Assertion helpers included by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset
`define CHK_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("check failed");
// Next-cycle implication outside reset
`define CHK_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("check failed");
`endif

// ----- sv/hsr_pkg.sv -----
package hsr_pkg;
   localparam int SEED_WORDS = 8;
   localparam logic [7:0] IPAD = 8'h36;
   localparam logic [7:0] OPAD = 8'h5C;
   localparam int CSR_IDX_W = 3;

   // Per-block control from the sequencer to the hash engine
   typedef struct packed {
      logic        start;
      logic [63:0] counter;
   } hsr_cmd_type;

   typedef struct packed {
      logic         done;
      logic [255:0] digest;
   } hsr_res_type;

   localparam logic [31:0] ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

   localparam logic [255:0] INIT_H = {
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

   function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
      rotr = (x >> n) | (x << (32 - n));
   endfunction
endpackage

// ----- sv/hsr_round.sv -----
// One SHA-256 round plus message schedule step; shared by all compressions
module hsr_round (
   input  logic [255:0] state_i,
   input  logic [511:0] sched_i,
   input  logic [5:0]   round_i,
   output logic [255:0] state_o,
   output logic [511:0] sched_o
);
   logic [31:0] a, b, c, d, e, f, g, h, w0, t1, t2, s0, s1, wn;

   always_comb begin
      {a, b, c, d, e, f, g, h} = state_i;
      w0 = sched_i[511:480];
      t1 = h + (hsr_pkg::rotr(e, 6) ^ hsr_pkg::rotr(e, 11) ^ hsr_pkg::rotr(e, 25))
           + ((e & f) ^ (~e & g)) + hsr_pkg::ROUND_K[round_i] + w0;
      t2 = (hsr_pkg::rotr(a, 2) ^ hsr_pkg::rotr(a, 13) ^ hsr_pkg::rotr(a, 22))
           + ((a & b) ^ (a & c) ^ (b & c));
      state_o = {t1 + t2, a, b, c, d + t1, e, f, g};
      // window holds w[i]..w[i+15], oldest in the top word
      s0 = hsr_pkg::rotr(sched_i[479:448], 7) ^ hsr_pkg::rotr(sched_i[479:448], 18)
           ^ (sched_i[479:448] >> 3);
      s1 = hsr_pkg::rotr(sched_i[63:32], 17) ^ hsr_pkg::rotr(sched_i[63:32], 19)
           ^ (sched_i[63:32] >> 10);
      wn = w0 + s0 + sched_i[223:192] + s1;
      sched_o = {sched_i[479:0], wn};
   end
endmodule

// ----- sv/hsr_engine.sv -----
// HMAC block engine: four compressions through one round unit
module hsr_engine (
   input  logic                clock,
   input  logic                reset,
   input  logic [511:0]        key_i,
   input  hsr_pkg::hsr_cmd_type cmd_i,
   output hsr_pkg::hsr_res_type res_o
);
   typedef enum logic [1:0] {IDLE, LOAD, RUN, FOLD} state_type;

   state_type    state_ff, state_in;
   logic [1:0]   comp_ff, comp_in;
   logic [5:0]   round_ff, round_in;
   logic [255:0] work_ff, work_in, hash_ff, hash_in, inner_ff, inner_in;
   logic [511:0] sched_ff, sched_in, blk;
   logic [63:0]  ctr_ff, ctr_in;
   logic         done_ff, done_in;
   logic [255:0] rstate;
   logic [511:0] rsched;
   logic [511:0] keyx;
   logic [63:0]  ctr_be;

   hsr_round u_round (.state_i(work_ff), .sched_i(sched_ff), .round_i(round_ff),
                      .state_o(rstate), .sched_o(rsched));

   // Build the message block for the current compression
   always_comb begin
      for (int i = 0; i < 64; i++)
         keyx[511 - 8*i -: 8] = key_i[8*i +: 8] ^ (comp_ff[1] ? hsr_pkg::OPAD : hsr_pkg::IPAD);
      for (int i = 0; i < 8; i++)
         ctr_be[63 - 8*i -: 8] = ctr_ff[8*i +: 8];
      case (comp_ff)
         2'd0, 2'd2: blk = keyx;
         2'd1: blk = {ctr_be, 8'h80, 376'd0, 64'd576};
         default: blk = {inner_ff, 8'h80, 184'd0, 64'd768};
      endcase
   end

   always_comb begin
      state_in = state_ff; comp_in = comp_ff; round_in = round_ff;
      work_in = work_ff; sched_in = sched_ff; hash_in = hash_ff;
      inner_in = inner_ff; ctr_in = ctr_ff; done_in = 1'b0;
      unique case (state_ff)
         IDLE: if (cmd_i.start) begin
            ctr_in = cmd_i.counter; comp_in = 2'd0;
            hash_in = hsr_pkg::INIT_H; state_in = LOAD;
         end
         LOAD: begin
            work_in = hash_ff; sched_in = blk; round_in = 6'd0; state_in = RUN;
         end
         RUN: begin
            work_in = rstate; sched_in = rsched; round_in = round_ff + 6'd1;
            if (round_ff == 6'd63) state_in = FOLD;
         end
         FOLD: begin
            for (int i = 0; i < 8; i++)
               hash_in[32*i +: 32] = hash_ff[32*i +: 32] + work_ff[32*i +: 32];
            comp_in = comp_ff + 2'd1;
            state_in = LOAD;
            if (comp_ff == 2'd1) begin
               inner_in = hash_in; hash_in = hsr_pkg::INIT_H;
            end else if (comp_ff == 2'd3) begin
               done_in = 1'b1; state_in = IDLE;
            end
         end
         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE; done_ff <= 1'b0; comp_ff <= 2'd0; round_ff <= 6'd0;
      end else begin
         state_ff <= state_in; done_ff <= done_in; comp_ff <= comp_in; round_ff <= round_in;
      end
      work_ff <= work_in; sched_ff <= sched_in; hash_ff <= hash_in;
      inner_ff <= inner_in; ctr_ff <= ctr_in;
   end

   assign res_o.done = done_ff;
   assign res_o.digest = hash_ff;
endmodule

// ----- sv/hmac_sha256_counter_random_bytes_top.sv -----
// HMAC-SHA256 counter-mode random byte source.
// Seed: eight 64-bit words, written through csr_we/csr_index/csr_wdata.
// Request: req_tdata[8:0] = byte count; values above MAX_REQUEST_BYTES saturate,
// zero gives no output and leaves the block counter alone.
// Response: one word per up to eight bytes on rsp_tdata[63:0], first byte low,
// unused bytes zero; rsp_tuser = valid byte count, rsp_tlast marks the final word.
// Each 32-byte block costs four compressions of 64 rounds through one shared
// round unit; the digest is then taken and handed out as four words, and the
// next block is started when the fourth word is issued. The user must write
// the seed only while idle; the block does not enforce it.
// req_tready is low while a request runs or a word waits.
// Word output waits while the receiver holds rsp_tready low; nothing is lost.
// The 64-bit block counter advances once per block, even a partly used one.
// Synchronous reset clears the counter, the seed, the state registers and the output valid flag.
module hmac_sha256_counter_random_bytes_top #(
   parameter int MAX_REQUEST_BYTES = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // request_bytes[8:0], zero fill
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // random_word[63:0]
   output logic [3:0]  rsp_tuser,   // valid_bytes[3:0]
   output logic        rsp_tlast,   // last_word
   input  logic        csr_we,
   input  logic [hsr_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [63:0] csr_wdata
);
   localparam int CW = $clog2(MAX_REQUEST_BYTES + 1);
   localparam int RW = (CW > 9) ? CW : 9;

   typedef enum logic [1:0] {IDLE, HASH, EMIT} state_type;

   state_type    state_ff, state_in;
   logic [511:0] seed_ff;
   logic [63:0]  ctr_ff, ctr_in;
   logic [RW-1:0] rem_ff, rem_in, req_sat;
   logic [1:0]   wsel_ff, wsel_in;
   logic [255:0] blk_ff, blk_in;
   logic         rv_ff, rv_in;
   logic [63:0]  rd_ff, rd_in, mask;
   logic [3:0]   ru_ff, ru_in, take;
   logic         rl_ff, rl_in;
   logic [63:0]  bword;
   hsr_pkg::hsr_cmd_type cmd;
   hsr_pkg::hsr_res_type res;

   hsr_engine u_engine (.clock(clock), .reset(reset), .key_i(seed_ff), .cmd_i(cmd), .res_o(res));

   // Seed registers
   always_ff @(posedge clock) begin
      if (reset) seed_ff <= '0;
      else if (csr_we) seed_ff[64*csr_index +: 64] <= csr_wdata;
   end

   always_comb begin
      req_sat = (RW'(req_tdata[8:0]) > RW'(MAX_REQUEST_BYTES)) ? RW'(MAX_REQUEST_BYTES)
                : RW'(req_tdata[8:0]);
      take = (rem_ff < RW'(8)) ? rem_ff[3:0] : 4'd8;
      mask = ~64'd0 >> (7'd64 - {take[3:0], 3'b000});
      // digest bytes leave in big-endian order, word 0 first
      for (int i = 0; i < 8; i++)
         bword[8*i +: 8] = blk_ff[255 - 64*wsel_ff - 8*i -: 8];
   end

   always_comb begin
      state_in = state_ff; ctr_in = ctr_ff; rem_in = rem_ff; wsel_in = wsel_ff;
      blk_in = blk_ff; rv_in = rv_ff; rd_in = rd_ff; ru_in = ru_ff; rl_in = rl_ff;
      cmd.start = 1'b0; cmd.counter = ctr_ff;
      if (rv_ff && rsp_tready) rv_in = 1'b0;
      unique case (state_ff)
         IDLE: if (req_tvalid && req_tready && req_sat != '0) begin
            rem_in = req_sat; cmd.start = 1'b1; state_in = HASH;
         end
         HASH: if (res.done) begin
            blk_in = res.digest; ctr_in = ctr_ff + 64'd1; wsel_in = 2'd0; state_in = EMIT;
         end
         EMIT: if (!rv_ff || rsp_tready) begin
            rv_in = 1'b1; rd_in = bword & mask; ru_in = take;
            rl_in = (rem_ff == RW'(take));
            rem_in = rem_ff - RW'(take);
            wsel_in = wsel_ff + 2'd1;
            if (rem_ff == RW'(take)) state_in = IDLE;
            else if (wsel_ff == 2'd3) begin
               cmd.start = 1'b1; state_in = HASH;
            end
         end
         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE; ctr_ff <= '0; rv_ff <= 1'b0;
      end else begin
         state_ff <= state_in; ctr_ff <= ctr_in; rv_ff <= rv_in;
      end
      rem_ff <= rem_in; wsel_ff <= wsel_in; blk_ff <= blk_in;
      rd_ff <= rd_in; ru_ff <= ru_in; rl_ff <= rl_in;
   end

   assign req_tready = (state_ff == IDLE) && !rv_ff;
   assign rsp_tvalid = rv_ff;
   assign rsp_tdata = rd_ff;
   assign rsp_tuser = ru_ff;
   assign rsp_tlast = rl_ff;
endmodule

// ----- sv/hsr_checker.sv -----
`include "assert_macros.svh"
// Port-level checks on the random byte source
module hsr_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [63:0] rsp_tdata,
   input logic [3:0]  rsp_tuser,
   input logic        rsp_tlast
);
   `CHK_IMPLY(a_count_range, clock, reset, rsp_tvalid, rsp_tuser >= 4'd1 && rsp_tuser <= 4'd8)
   `CHK_IMPLY(a_short_last, clock, reset, rsp_tvalid && rsp_tuser != 4'd8, rsp_tlast)
   `CHK_IMPLY(a_no_accept_busy, clock, reset, rsp_tvalid, !req_tready)
   `CHK_NEXT(a_hold, clock, reset, rsp_tvalid && !rsp_tready,
             rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
endmodule

bind hmac_sha256_counter_random_bytes_top hsr_checker u_hsr_checker (.*);

// ----- tb/sv/hmac_sha256_counter_random_bytes_top_test.sv -----
`timescale 1ns / 1ps

module hmac_sha256_counter_random_bytes_top_test;

   localparam int MAX_BYTES = 256;
   localparam int WATCH_LIMIT = 200000;
   localparam int DRAIN_CYCLES = 3000;

   // Register indexes of the seed words
   typedef enum logic [hsr_pkg::CSR_IDX_W-1:0] {
      SEED_W0, SEED_W1, SEED_W2, SEED_W3, SEED_W4, SEED_W5, SEED_W6, SEED_W7
   } seed_reg_type;

   typedef struct packed {
      logic [63:0] data;
      logic [3:0]  nbytes;
      logic        last;
   } word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;
   logic [3:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_we = 1'b0;
   logic [hsr_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [63:0] csr_wdata = '0;

   hmac_sha256_counter_random_bytes_top #(.MAX_REQUEST_BYTES(MAX_BYTES)) i_dut (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Predictor state
   logic [63:0] seed_q [8];
   logic [63:0] blk_count;
   word_type    words_due [$];
   int          n_errors = 0;
   int          idle_cycles = 0;
   bit          rx_hold = 1'b0;
   int          rx_hold_len = 0;

   localparam logic [31:0] K_TAB [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

   function automatic logic [31:0] ror32(logic [31:0] x, int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   // One SHA-256 compression over a 64-byte chunk
   function automatic void sha_chunk(ref logic [31:0] h [8], input logic [7:0] m [128],
                                     input int base);
      logic [31:0] w [64];
      logic [31:0] a, b, c, d, e, f, g, hh, t1, t2, s0, s1;
      for (int i = 0; i < 16; i++)
         w[i] = {m[base+4*i], m[base+4*i+1], m[base+4*i+2], m[base+4*i+3]};
      for (int i = 16; i < 64; i++) begin
         s0 = ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3);
         s1 = ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10);
         w[i] = w[i-16] + s0 + w[i-7] + s1;
      end
      a = h[0]; b = h[1]; c = h[2]; d = h[3]; e = h[4]; f = h[5]; g = h[6]; hh = h[7];
      for (int i = 0; i < 64; i++) begin
         t1 = hh + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g))
              + K_TAB[i] + w[i];
         t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
         hh = g; g = f; f = e; e = d + t1; d = c; c = b; b = a; a = t1 + t2;
      end
      h[0] += a; h[1] += b; h[2] += c; h[3] += d;
      h[4] += e; h[5] += f; h[6] += g; h[7] += hh;
   endfunction

   // Hash of a 64-byte padded key plus a short tail (fits two chunks)
   function automatic void sha_two(input logic [7:0] msg [96], input int len,
                                   output logic [7:0] dig [32]);
      logic [7:0]  buf_b [128];
      logic [31:0] h [8];
      logic [63:0] nbits;
      nbits = 64'(len) * 64'd8;
      for (int i = 0; i < 128; i++) buf_b[i] = (i < len) ? msg[i] : 8'h00;
      buf_b[len] = 8'h80;
      for (int i = 0; i < 8; i++) buf_b[127-i] = nbits[8*i +: 8];
      h = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
            32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
      sha_chunk(h, buf_b, 0);
      sha_chunk(h, buf_b, 64);
      for (int i = 0; i < 32; i++) dig[i] = h[i/4][8*(3-i%4) +: 8];
   endfunction

   // HMAC of the block counter keyed by the seed
   function automatic void hmac_block(input logic [63:0] ctr, output logic [7:0] dig [32]);
      logic [7:0] msg [96];
      logic [7:0] inner [32];
      for (int i = 0; i < 64; i++) msg[i] = seed_q[i/8][8*(i%8) +: 8] ^ hsr_pkg::IPAD;
      for (int i = 0; i < 8; i++) msg[64+i] = ctr[8*i +: 8];
      for (int i = 72; i < 96; i++) msg[i] = 8'h00;
      sha_two(msg, 72, inner);
      for (int i = 0; i < 64; i++) msg[i] = seed_q[i/8][8*(i%8) +: 8] ^ hsr_pkg::OPAD;
      for (int i = 0; i < 32; i++) msg[64+i] = inner[i];
      sha_two(msg, 96, dig);
   endfunction

   // Expected words for one request
   function automatic void predict_words(input logic [8:0] nreq);
      logic [7:0] dig [32];
      int remaining, pos, take;
      word_type wd;
      remaining = (nreq > MAX_BYTES) ? MAX_BYTES : nreq;
      pos = 0;
      while (remaining > 0) begin
         take = remaining < 8 ? remaining : 8;
         if (pos % 32 == 0) begin
            hmac_block(blk_count, dig);
            blk_count++;
         end
         wd.data = '0;
         for (int i = 0; i < take; i++) wd.data[8*i +: 8] = dig[(pos + i) % 32];
         pos += take;
         remaining -= take;
         wd.nbytes = 4'(take);
         wd.last = (remaining == 0);
         words_due.push_back(wd);
      end
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
      n_errors++;
   endtask

   // Compare each accepted word against the oldest expectation
   always @(posedge clock) begin
      word_type wd;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (words_due.size() == 0) begin
            report_mismatch("unexpected word", rsp_tdata, 64'h0);
         end else begin
            wd = words_due.pop_front();
            if (rsp_tdata !== wd.data) report_mismatch("random_word", rsp_tdata, wd.data);
            if (rsp_tuser !== wd.nbytes)
               report_mismatch("valid_bytes", 64'(rsp_tuser), 64'(wd.nbytes));
            if (rsp_tlast !== wd.last)
               report_mismatch("last_word", 64'(rsp_tlast), 64'(wd.last));
         end
      end
   end

   // Watchdog on cycles without any handshake
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCH_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Receiver: random stalls, plus one long hold-off on request
   initial begin
      int gap;
      @(negedge clock);
      forever begin
         if (rx_hold) begin
            rsp_tready <= 1'b0;
            repeat (rx_hold_len) @(negedge clock);
            rx_hold = 1'b0;
         end
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         @(negedge clock);
      end
   end

   task automatic write_seed(input seed_reg_type idx, input logic [63:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      seed_q[idx] = val;
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   // Offer one request; the idle gap after it drops req_tvalid unless it is zero
   task automatic send_request(input logic [8:0] nreq, input bit no_gaps);
      int gap;
      req_tvalid <= 1'b1;
      req_tdata <= {7'd0, nreq};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_words(nreq);
      gap = no_gaps ? 0 : $urandom_range(0, 14);
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   // Wait out all expected words and the engine tail before touching the seed
   task automatic wait_idle;
      req_tvalid <= 1'b0;
      while (words_due.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // Directed requests: extremes, zero, saturation, partial words, block edges
   localparam int N_DIR = 16;
   localparam logic [8:0] DIR_REQ [N_DIR] = '{
      9'd1, 9'd0, 9'd8, 9'd7, 9'd9, 9'd31, 9'd32, 9'd33,
      9'd0, 9'd256, 9'd257, 9'd511, 9'd64, 9'd255, 9'd2, 9'd170};

   initial begin
      for (int i = 0; i < 8; i++) seed_q[i] = '0;
      blk_count = '0;
      repeat (2) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // all-zero seed after reset, then directed rows
      for (int i = 0; i < N_DIR; i++) send_request(DIR_REQ[i], i > 10);
      wait_idle();

      // all-ones seed
      for (int i = 0; i < 8; i++) write_seed(seed_reg_type'(i), '1);
      send_request(9'd40, 1'b0);
      send_request(9'd3, 1'b0);
      wait_idle();

      // random seeds in phases; random request sizes, mostly small
      for (int ph = 0; ph < 4; ph++) begin
         for (int i = 0; i < 8; i++) write_seed(seed_reg_type'(i), {$urandom, $urandom});
         for (int n = 0; n < 40; n++) begin
            case ($urandom_range(0, 9))
               0: send_request(9'($urandom_range(257, 511)), 1'b0);
               1: send_request(9'($urandom_range(200, 256)), 1'b0);
               2: send_request(9'd0, 1'b0);
               default: send_request(9'($urandom_range(1, 48)), 1'b0);
            endcase
            // long receiver hold-off while requests keep coming
            if (ph == 1 && n == 5) begin
               rx_hold_len = 3000;
               rx_hold = 1'b1;
            end
            // sender pause until every expected word is back
            if (ph == 2 && n == 20) begin
               req_tvalid <= 1'b0;
               while (words_due.size() != 0) @(negedge clock);
            end
         end
         wait_idle();
      end

      if (n_errors == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end
endmodule
